// ===== hw/rtl/fvg_pkg.sv =====
// Shared constants and types for the FAT volume geometry pipeline.
`timescale 1ns / 1ps
`default_nettype none

package fvg_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int ROOT_ENTRIES = 512;
    localparam int SB_SHIFT     = $clog2(SECTOR_BYTES);

    // Root directory sectors plus one spare, plus one reserved sector.
    localparam int OVERHEAD = (ROOT_ENTRIES * 32 + SECTOR_BYTES + 1) / SECTOR_BYTES + 1;

    localparam int VOL_W      = 32;
    localparam int Q_W        = 32;
    localparam int NUM_W      = VOL_W + SB_SHIFT;
    localparam int DIVISOR_W  = $clog2(64 * SECTOR_BYTES + 4 + 1);
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = Q_W / DIV_STAGES;

    // Accepting edge to the edge that loads the result registers.
    localparam int PIPE_LAT = DIV_STAGES + 3;

    localparam logic [VOL_W-1:0] CS64_MIN = 32'd2098000;
    localparam logic [VOL_W-1:0] CS32_MIN = 32'd1050000;
    localparam logic [VOL_W-1:0] CS16_MIN = 32'd526000;
    localparam logic [VOL_W-1:0] CS8_MIN  = 32'd264000;
    localparam logic [VOL_W-1:0] CS4_MIN  = 32'd132000;
    localparam logic [VOL_W-1:0] CS2_MIN  = 32'd68000;

    localparam logic [Q_W-1:0] FAT12_LIMIT = 32'd4086;
    localparam logic [VOL_W-1:0] SMALL_LIMIT = 32'd65536;

    typedef logic [VOL_W-1:0]     vol_t;
    typedef logic [DIVISOR_W-1:0] divisor_t;
    typedef logic [Q_W-1:0]       quot_t;

    typedef struct packed {
        vol_t        vol;
        logic [2:0]  cs_shift;
        logic [4:0]  head_shift;
        logic [15:0] track;
        logic        too_small;
    } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fvg_divider.sv =====
// Pipelined restoring divider: (usable * sector bytes) / divisor, four quotient bits a stage.
`timescale 1ns / 1ps
`default_nettype none

module fvg_divider (
    input  logic                      clk,
    input  logic [fvg_pkg::NUM_W-1:0] num,
    input  fvg_pkg::divisor_t         divisor,
    output fvg_pkg::quot_t            quotient
);
    import fvg_pkg::*;

    divisor_t rem_reg [DIV_STAGES];
    quot_t    low_reg [DIV_STAGES];
    quot_t    quo_reg [DIV_STAGES];
    divisor_t div_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            divisor_t rem_in;
            quot_t    low_in;
            quot_t    quo_in;
            divisor_t div_in;
            divisor_t rem_next;
            quot_t    low_next;
            quot_t    quo_next;

            if (s == 0)
            begin : g_first
                // Top dividend bits are below the divisor, so the quotient fits Q_W bits.
                assign rem_in = DIVISOR_W'(num[NUM_W-1:Q_W]);
                assign low_in = num[Q_W-1:0];
                assign quo_in = '0;
                assign div_in = divisor;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign div_in = div_reg[s-1];
            end

            always_comb
            begin
                logic [DIVISOR_W:0] trial;
                rem_next = rem_in;
                low_next = low_in;
                quo_next = quo_in;
                for (int j = 0; j < DIV_BITS; j++)
                begin
                    trial = {rem_next, low_next[Q_W-1]};
                    low_next = {low_next[Q_W-2:0], 1'b0};
                    if (trial >= {1'b0, div_in})
                    begin
                        trial = trial - {1'b0, div_in};
                        quo_next = {quo_next[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_next[Q_W-2:0], 1'b0};
                    end
                    rem_next = trial[DIVISOR_W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                low_reg[s] <= low_next;
                quo_reg[s] <= quo_next;
                div_reg[s] <= div_in;
            end
        end
    endgenerate

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/fat_volume_geometry.sv =====
// Top level: FAT12/FAT16 layout parameters computed from a volume size.
// Output: done is registered and rises together with the result registers that it qualifies.
// Throughput: one transaction per cycle; busy stays low, start may be high every cycle.
// The eight-stage quotient pipeline (two dividers side by side) makes up most of the latency.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// The receiver cannot stall, so no result is ever held back in the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module fat_volume_geometry (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [fvg_pkg::VOL_W-1:0]  volume_sectors,
    output logic                       done,
    output logic                       fat_type,
    output logic [6:0]                 cluster_sectors,
    output logic [16:0]                head_count,
    output logic [15:0]                track_sectors,
    output logic [31:0]                clusters,
    output logic [31:0]                fat_sectors,
    output logic [15:0]                small_count,
    output logic [31:0]                large_count,
    output logic                       too_small
);
    import fvg_pkg::*;

    // Stage A: captured volume.
    logic va_reg;
    vol_t vol_a_reg;

    // Stage A combinational decode.
    logic [2:0]  cs_shift_a;
    logic [4:0]  head_shift_a;
    vol_t        usable_a;
    logic        too_small_a;
    logic [6:0]  cs_a;
    side_t       side_a;

    // Stage B: divider operands.
    logic     vb_reg;
    vol_t     usable_b_reg;
    divisor_t div12_b_reg;
    divisor_t div16_b_reg;
    side_t    side_b_reg;

    // Sideband alongside the dividers.
    logic  vd_reg   [DIV_STAGES];
    side_t side_d_reg [DIV_STAGES];
    quot_t q12;
    quot_t q16;

    // Stage C.
    logic          vc_reg;
    quot_t         c12_reg;
    quot_t         c16_reg;
    logic          over_reg;
    logic [Q_W:0]  half12_reg;
    side_t         side_c_reg;
    logic [Q_W+1:0] half12_next;

    // Output stage.
    logic [Q_W+1:0] f12_sum;
    logic [Q_W+1:0] f16_sum;
    logic           done_reg;
    logic           fat_type_reg;
    logic [6:0]     cluster_sectors_reg;
    logic [16:0]    head_count_reg;
    logic [15:0]    track_sectors_reg;
    quot_t          clusters_reg;
    quot_t          fat_sectors_reg;
    logic [15:0]    small_count_reg;
    vol_t           large_count_reg;
    logic           too_small_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        vol_a_reg <= volume_sectors;
    end

    always_comb
    begin
        priority if (vol_a_reg >= CS64_MIN) cs_shift_a = 3'd6;
        else if (vol_a_reg >= CS32_MIN)     cs_shift_a = 3'd5;
        else if (vol_a_reg >= CS16_MIN)     cs_shift_a = 3'd4;
        else if (vol_a_reg >= CS8_MIN)      cs_shift_a = 3'd3;
        else if (vol_a_reg >= CS4_MIN)      cs_shift_a = 3'd2;
        else if (vol_a_reg >= CS2_MIN)      cs_shift_a = 3'd1;
        else                                cs_shift_a = 3'd0;
    end

    // Smallest shift of at least one that brings the volume under 65536.
    always_comb
    begin
        head_shift_a = 5'd1;
        for (int j = 17; j < VOL_W; j++)
        begin
            if (vol_a_reg[j])
            begin
                head_shift_a = 5'(j - 15);
            end
        end
    end

    assign too_small_a = vol_a_reg < VOL_W'(OVERHEAD);
    assign usable_a    = too_small_a ? '0 : vol_a_reg - VOL_W'(OVERHEAD);
    assign cs_a        = 7'd1 << cs_shift_a;

    always_comb
    begin
        side_a.vol        = vol_a_reg;
        side_a.cs_shift   = cs_shift_a;
        side_a.head_shift = head_shift_a;
        side_a.track      = 16'(vol_a_reg >> head_shift_a);
        side_a.too_small  = too_small_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        usable_b_reg <= usable_a;
        div12_b_reg  <= (DIVISOR_W'(cs_a) << SB_SHIFT) + DIVISOR_W'(3);
        div16_b_reg  <= (DIVISOR_W'(cs_a) << SB_SHIFT) + DIVISOR_W'(4);
        side_b_reg   <= side_a;
    end

    fvg_divider u_div12 (
        .clk      (clk),
        .num      ({usable_b_reg, SB_SHIFT'(0)}),
        .divisor  (div12_b_reg),
        .quotient (q12)
    );

    fvg_divider u_div16 (
        .clk      (clk),
        .num      ({usable_b_reg, SB_SHIFT'(0)}),
        .divisor  (div16_b_reg),
        .quotient (q16)
    );

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vd_reg[s] <= 1'b0;
                end
                else
                begin
                    vd_reg[s] <= (s == 0) ? vb_reg : vd_reg[(s == 0) ? 0 : s - 1];
                end
            end

            always_ff @(posedge clk)
            begin
                side_d_reg[s] <= (s == 0) ? side_b_reg : side_d_reg[(s == 0) ? 0 : s - 1];
            end
        end
    endgenerate

    assign half12_next = ({2'b00, q12} + {1'b0, q12, 1'b0} + (Q_W+2)'(1)) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vd_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c12_reg    <= q12;
        c16_reg    <= q16;
        over_reg   <= q12 > FAT12_LIMIT;
        half12_reg <= half12_next[Q_W:0];
        side_c_reg <= side_d_reg[DIV_STAGES-1];
    end

    assign f12_sum = {1'b0, half12_reg} + (Q_W+2)'(SECTOR_BYTES + 1);
    assign f16_sum = {1'b0, c16_reg, 1'b0} + (Q_W+2)'(SECTOR_BYTES + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fat_type_reg        <= over_reg;
        cluster_sectors_reg <= 7'd1 << side_c_reg.cs_shift;
        head_count_reg      <= 17'd1 << side_c_reg.head_shift;
        track_sectors_reg   <= side_c_reg.track;
        clusters_reg        <= over_reg ? c16_reg : c12_reg;
        fat_sectors_reg     <= over_reg ? Q_W'(f16_sum >> SB_SHIFT) : Q_W'(f12_sum >> SB_SHIFT);
        too_small_reg       <= side_c_reg.too_small;
        if (side_c_reg.vol >= SMALL_LIMIT)
        begin
            small_count_reg <= '0;
            large_count_reg <= side_c_reg.vol;
        end
        else
        begin
            small_count_reg <= side_c_reg.vol[15:0];
            large_count_reg <= '0;
        end
    end

    assign done            = done_reg;
    assign fat_type        = fat_type_reg;
    assign cluster_sectors = cluster_sectors_reg;
    assign head_count      = head_count_reg;
    assign track_sectors   = track_sectors_reg;
    assign clusters        = clusters_reg;
    assign fat_sectors     = fat_sectors_reg;
    assign small_count     = small_count_reg;
    assign large_count     = large_count_reg;
    assign too_small       = too_small_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fvg_checker.sv =====
// Port-level checks for fat_volume_geometry, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fvg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        fat_type,
    input logic [16:0] head_count,
    input logic [31:0] clusters,
    input logic [15:0] small_count,
    input logic [31:0] large_count,
    input logic        too_small
);
    import fvg_pkg::*;

    // Result registers load at the end of the pipeline; done is sampled at the edge after that.
    // Every accepted transaction yields a result on schedule.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(PIPE_LAT + 1) done)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT + 1))
        else $error("result without an accepted transaction");

    a_too_small: assert property (@(posedge clk) disable iff (!rst_n)
        (done && too_small) |-> (!fat_type && clusters == 32'd0))
        else $error("undersized volume reported clusters or FAT16");

    a_count_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (small_count == 16'd0 || large_count == 32'd0))
        else $error("both sector count fields are nonzero");

    a_heads_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($onehot(head_count) && !head_count[0]))
        else $error("head count is not a power of two of at least 2");

endmodule

bind fat_volume_geometry fvg_checker u_fvg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .fat_type    (fat_type),
    .head_count  (head_count),
    .clusters    (clusters),
    .small_count (small_count),
    .large_count (large_count),
    .too_small   (too_small)
);

`default_nettype wire

// ===== bench/fat_volume_geometry_tb.sv =====
// Self-checking bench for the FAT volume geometry block: predicted layouts vs. results.
`timescale 1ns / 1ps

module fat_volume_geometry_tb;

    import fvg_pkg::*;

    typedef struct packed {
        logic        fat16;
        logic [6:0]  cs;
        logic [16:0] heads;
        logic [15:0] track;
        logic [31:0] clusters;
        logic [31:0] fat_len;
        logic [15:0] sec16;
        logic [31:0] sec32;
        logic        too_small;
    } fat_layout_t;

    typedef struct {
        vol_t vol;
        int   idle_pct;
        logic drain;
    } volume_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    vol_t        volume_sectors = '0;
    logic        done;
    logic        fat_type;
    logic [6:0]  cluster_sectors;
    logic [16:0] head_count;
    logic [15:0] track_sectors;
    logic [31:0] clusters;
    logic [31:0] fat_sectors;
    logic [15:0] small_count;
    logic [31:0] large_count;
    logic        too_small;

    volume_req_t volume_reqs[$];
    fat_layout_t expected_layouts[$];
    logic        handed_off = 1'b0;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_errors = 0;

    vol_t boundaries [14] = '{
        32'd0, 32'd34, 32'd4145, 32'd65536, 32'd68000, 32'd131072, 32'd132000,
        32'd264000, 32'd526000, 32'd1050000, 32'd2098000, 32'h0100_0000,
        32'h8000_0000, 32'hFFFF_FFFF
    };

    fat_volume_geometry u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .volume_sectors  (volume_sectors),
        .done            (done),
        .fat_type        (fat_type),
        .cluster_sectors (cluster_sectors),
        .head_count      (head_count),
        .track_sectors   (track_sectors),
        .clusters        (clusters),
        .fat_sectors     (fat_sectors),
        .small_count     (small_count),
        .large_count     (large_count),
        .too_small       (too_small)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic fat_layout_t predict_layout(input vol_t n);
        logic [63:0] sb;
        logic [63:0] cs;
        logic [63:0] heads;
        logic [63:0] overhead;
        logic [63:0] usable;
        logic [63:0] cnt;
        logic [63:0] fat_len;
        logic [63:0] n64;
        fat_layout_t r;
        sb  = 64'(SECTOR_BYTES);
        n64 = {32'b0, n};
        if (n >= CS64_MIN)     cs = 64;
        else if (n >= CS32_MIN) cs = 32;
        else if (n >= CS16_MIN) cs = 16;
        else if (n >= CS8_MIN)  cs = 8;
        else if (n >= CS4_MIN)  cs = 4;
        else if (n >= CS2_MIN)  cs = 2;
        else                    cs = 1;
        heads = 2;
        while (heads < 64'd65536 && (n64 / heads) >= 64'd65536)
            heads = heads << 1;
        overhead = (64'(ROOT_ENTRIES) * 32 + sb + 1) / sb + 1;
        r.too_small = (n64 < overhead);
        usable = r.too_small ? 64'd0 : n64 - overhead;
        // Try FAT12 first, fall back to FAT16 once the cluster count overflows it.
        cnt     = (usable * sb) / (cs * sb + 3);
        fat_len = (((cnt * 3 + 1) >> 1) + sb + 1) / sb;
        r.fat16 = 1'b0;
        if (cnt > 64'(FAT12_LIMIT))
        begin
            r.fat16 = 1'b1;
            cnt     = (usable * sb) / (cs * sb + 4);
            fat_len = (cnt * 2 + sb + 1) / sb;
        end
        r.cs       = cs[6:0];
        r.heads    = heads[16:0];
        r.track    = 16'(n64 / heads);
        r.clusters = cnt[31:0];
        r.fat_len  = fat_len[31:0];
        r.sec16    = (n >= SMALL_LIMIT) ? 16'd0 : n[15:0];
        r.sec32    = (n >= SMALL_LIMIT) ? n : 32'd0;
        return r;
    endfunction

    // Mostly sizes spread over every magnitude, some near the ladder and head edges.
    function automatic vol_t random_volume();
        int unsigned pick;
        int unsigned bits;
        vol_t v;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            bits = $urandom_range(32, 1);
            v = $urandom;
            if (bits < 32)
                v = v & ((32'd1 << bits) - 32'd1);
        end
        else if (pick < 75)
            v = $urandom;
        else
            v = boundaries[$urandom_range(13)] + $urandom_range(8) - 32'd4;
        return v;
    endfunction

    task automatic queue_volume(input vol_t v, input int idle_pct, input logic drain);
        volume_req_t req;
        req.vol      = v;
        req.idle_pct = idle_pct;
        req.drain    = drain;
        volume_reqs.push_back(req);
        n_queued++;
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                     n_results, field, want, got);
    endtask

    always @(negedge clk)
    begin : driver
        if (!rst_n)
            start <= 1'b0;
        else if (!start || handed_off)
        begin
            // Hold the first transaction of a phase until the pipeline has drained.
            if (volume_reqs.size() != 0
                && !(volume_reqs[0].drain && expected_layouts.size() != 0)
                && $urandom_range(99) >= volume_reqs[0].idle_pct)
            begin
                start          <= 1'b1;
                volume_sectors <= volume_reqs[0].vol;
                void'(volume_reqs.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        fat_layout_t want;
        fat_layout_t got;
        if (!rst_n)
            handed_off <= 1'b0;
        else
        begin
            handed_off <= start && !busy;
            if (done)
            begin
                got = {fat_type, cluster_sectors, head_count, track_sectors, clusters,
                       fat_sectors, small_count, large_count, too_small};
                if (expected_layouts.size() == 0)
                    note_mismatch("unexpected result", 64'd0, 64'(got.sec32));
                else
                begin
                    want = expected_layouts.pop_front();
                    if (got.fat16 !== want.fat16)
                        note_mismatch("fat_type", want.fat16, got.fat16);
                    if (got.cs !== want.cs)
                        note_mismatch("cluster_sectors", want.cs, got.cs);
                    if (got.heads !== want.heads)
                        note_mismatch("head_count", want.heads, got.heads);
                    if (got.track !== want.track)
                        note_mismatch("track_sectors", want.track, got.track);
                    if (got.clusters !== want.clusters)
                        note_mismatch("clusters", want.clusters, got.clusters);
                    if (got.fat_len !== want.fat_len)
                        note_mismatch("fat_sectors", want.fat_len, got.fat_len);
                    if (got.sec16 !== want.sec16)
                        note_mismatch("small_count", want.sec16, got.sec16);
                    if (got.sec32 !== want.sec32)
                        note_mismatch("large_count", want.sec32, got.sec32);
                    if (got.too_small !== want.too_small)
                        note_mismatch("too_small", want.too_small, got.too_small);
                end
                n_results++;
            end
            if (start && !busy)
            begin
                expected_layouts.push_back(predict_layout(volume_sectors));
                n_accepted++;
            end
        end
    end

    initial
    begin : stimulus
        int idle_by_phase [4];
        vol_t directed [25];
        idle_by_phase = '{0, 79, 0, 14};
        // Overhead edges, FAT12/FAT16 switch, head and ladder thresholds, extremes.
        directed = '{
            32'd0, 32'd1, 32'd33, 32'd34, 32'd35, 32'd4144, 32'd4145, 32'd65535,
            32'd65536, 32'd67999, 32'd68000, 32'd131071, 32'd131072, 32'd131999,
            32'd132000, 32'd263999, 32'd264000, 32'd525999, 32'd526000, 32'd1049999,
            32'd1050000, 32'd2097999, 32'd2098000, 32'h8000_0000, 32'hFFFF_FFFF
        };
        foreach (directed[i])
            queue_volume(directed[i], idle_by_phase[0], i == 0);
        for (int p = 0; p < 4; p++)
            for (int i = 0; i < 235; i++)
                queue_volume(random_volume(), idle_by_phase[p], p != 0 && i == 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_queued || expected_layouts.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        n_errors += expected_layouts.size();
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #400_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fvg_pkg.sv
hw/rtl/fvg_divider.sv
hw/rtl/fat_volume_geometry.sv
hw/rtl/fvg_checker.sv
bench/fat_volume_geometry_tb.sv
